// ===== design/sitf_pkg.sv =====
// shared types and constants for the serial idle timeout framer
package sitf_pkg;

    localparam int BUF_DEPTH = 2048;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > 12) ? CNT_W : 12;
    localparam int WIDE_W    = CNT_W + 12;

    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_STX    = 8'h02;
    localparam logic [5:0] RETRY_MAX = 6'd63;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] CFG_YMODEM_MODE = 2'd0;
    localparam logic [1:0] CFG_SHORT_THR   = 2'd1;
    localparam logic [1:0] CFG_LONG_THR    = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd3;

    localparam logic [11:0] SHORT_THR_RESET   = 12'd127;
    localparam logic [11:0] LONG_THR_RESET    = 12'd1023;
    localparam logic [5:0]  RETRY_LIMIT_RESET = 6'd30;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic [10:0] read_index;
    } sitf_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] frame_length;
        logic        frame_closed;
        logic        timer_enable;
        logic        timer_restart;
        logic        byte_dropped;
    } sitf_out_t;

endpackage

// ===== design/serial_idle_timeout_framer_unit.sv =====
// serial idle timeout framer: frame buffer memory, control state and result register
// a word's result is registered in the read stage, then in the result register, before it is shown
// throughput: one word per cycle unless m_ready stalls the output, set by the single-port
// buffer memory (one write or one read); the memory is read into a registered read stage
// reset: aresetn synchronous active low; control state and registers reset, buffer
// contents are left as they are and need no clearing pass
module serial_idle_timeout_framer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sitf_pkg::sitf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sitf_pkg::sitf_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_wdata
);

    logic [7:0] buf_mem [sitf_pkg::BUF_DEPTH];
    logic [7:0] mem_rdata_reg;

    logic        ymodem_mode_reg;
    logic [11:0] short_thr_reg;
    logic [11:0] long_thr_reg;
    logic [5:0]  retry_limit_reg;

    logic [7:0]                first_byte_reg, first_byte_next;
    logic [sitf_pkg::CNT_W-1:0] write_index_reg, write_index_next;
    logic [sitf_pkg::CNT_W-1:0] pending_len_reg, pending_len_next;
    logic [5:0]                retry_count_reg, retry_count_next;
    logic                      timer_running_reg, timer_running_next;

    logic      s1_valid_reg;
    logic      s1_rd_reg, s1_rd_next;
    sitf_pkg::sitf_out_t s1_out_reg, s1_out_next;
    sitf_pkg::sitf_out_t s1_shown;
    sitf_pkg::sitf_out_t out_reg;
    logic      out_valid_reg;

    logic accept;
    logic s1_adv;
    logic wr_en;
    logic rd_en;
    logic [sitf_pkg::ADDR_W-1:0] wr_addr;
    logic [sitf_pkg::ADDR_W-1:0] rd_addr;
    logic [sitf_pkg::WIDE_W-1:0] ridx_wide;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign ridx_wide = sitf_pkg::WIDE_W'(s_data.read_index);
    assign rd_addr   = ridx_wide[sitf_pkg::ADDR_W-1:0];
    assign wr_addr   = write_index_reg[sitf_pkg::ADDR_W-1:0];

    // next state of the framer for the word at the input
    always_comb begin
        logic                      do_close;
        logic                      stop_timer;
        logic [5:0]                retry_inc;
        logic [11:0]               thr;
        logic [sitf_pkg::CMP_W-1:0] idx_cmp;
        do_close           = 1'b0;
        stop_timer         = 1'b0;
        retry_inc          = retry_count_reg;
        thr                = short_thr_reg;
        idx_cmp            = sitf_pkg::CMP_W'(write_index_reg);
        first_byte_next    = first_byte_reg;
        write_index_next   = write_index_reg;
        pending_len_next   = pending_len_reg;
        retry_count_next   = retry_count_reg;
        timer_running_next = timer_running_reg;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        s1_rd_next         = 1'b0;
        s1_out_next        = '0;

        case (s_data.kind)
            sitf_pkg::KIND_BYTE: begin
                if (write_index_reg >= sitf_pkg::CNT_W'(sitf_pkg::BUF_DEPTH)
                    || pending_len_reg != '0) begin
                    s1_out_next.byte_dropped = 1'b1;
                end else begin
                    wr_en = accept;
                    if (write_index_reg == '0) begin
                        first_byte_next = s_data.rx_byte;
                    end
                    write_index_next   = write_index_reg + 1'b1;
                    retry_count_next   = '0;
                    timer_running_next = 1'b1;
                    s1_out_next.timer_restart = 1'b1;
                end
            end
            sitf_pkg::KIND_EXPIRY: begin
                if (timer_running_reg) begin
                    if (!ymodem_mode_reg) begin
                        do_close   = 1'b1;
                        stop_timer = 1'b1;
                    end else if (first_byte_reg == sitf_pkg::CH_SOH
                                 || first_byte_reg == sitf_pkg::CH_STX) begin
                        if (first_byte_reg == sitf_pkg::CH_STX) begin
                            thr = long_thr_reg;
                        end
                        if (idx_cmp >= sitf_pkg::CMP_W'(thr)) begin
                            do_close   = 1'b1;
                            stop_timer = 1'b1;
                        end else begin
                            s1_out_next.timer_restart = 1'b1;
                            if (retry_count_reg < sitf_pkg::RETRY_MAX) begin
                                retry_inc = retry_count_reg + 1'b1;
                            end
                            retry_count_next = retry_inc;
                            if (retry_inc > retry_limit_reg) begin
                                do_close = 1'b1;
                            end
                        end
                    end else begin
                        do_close   = 1'b1;
                        stop_timer = 1'b1;
                    end
                end
            end
            sitf_pkg::KIND_RELEASE: begin
                pending_len_next = '0;
            end
            sitf_pkg::KIND_READ: begin
                if (ridx_wide < sitf_pkg::WIDE_W'(sitf_pkg::BUF_DEPTH)) begin
                    rd_en      = accept;
                    s1_rd_next = 1'b1;
                end
            end
            default: begin
                s1_out_next = '0;
            end
        endcase

        if (do_close) begin
            pending_len_next = write_index_reg;
            write_index_next = '0;
            s1_out_next.frame_closed = 1'b1;
        end
        if (stop_timer) begin
            timer_running_next = 1'b0;
        end
        s1_out_next.frame_length = 12'(pending_len_next);
        s1_out_next.timer_enable = timer_running_next;
    end

    // read stage word with the buffer byte merged in
    always_comb begin
        s1_shown           = s1_out_reg;
        s1_shown.read_data = s1_rd_reg ? mem_rdata_reg : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_addr] <= s_data.rx_byte;
        end
        if (rd_en) begin
            mem_rdata_reg <= buf_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ymodem_mode_reg <= 1'b0;
            short_thr_reg   <= sitf_pkg::SHORT_THR_RESET;
            long_thr_reg    <= sitf_pkg::LONG_THR_RESET;
            retry_limit_reg <= sitf_pkg::RETRY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sitf_pkg::CFG_YMODEM_MODE: ymodem_mode_reg <= cfg_wdata[0];
                sitf_pkg::CFG_SHORT_THR:   short_thr_reg   <= cfg_wdata;
                sitf_pkg::CFG_LONG_THR:    long_thr_reg    <= cfg_wdata;
                sitf_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_byte_reg    <= '0;
            write_index_reg   <= '0;
            pending_len_reg   <= '0;
            retry_count_reg   <= '0;
            timer_running_reg <= 1'b0;
        end else if (accept) begin
            first_byte_reg    <= first_byte_next;
            write_index_reg   <= write_index_next;
            pending_len_reg   <= pending_len_next;
            retry_count_reg   <= retry_count_next;
            timer_running_reg <= timer_running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_out_reg <= s1_out_next;
            s1_rd_reg  <= s1_rd_next;
        end
        if (s1_adv) begin
            out_reg <= s1_shown;
        end
    end

    a_pending_empty_index : assert property (@(posedge aclk) disable iff (!aresetn)
        pending_len_reg != '0 |-> write_index_reg == '0)
        else $error("write index not cleared while a frame is pending");

    a_index_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        write_index_reg <= sitf_pkg::CNT_W'(sitf_pkg::BUF_DEPTH))
        else $error("write index beyond buffer depth");

    a_drop_no_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_dropped |-> !m_data.timer_restart && !m_data.frame_closed)
        else $error("dropped word also restarted the timer or closed a frame");

    a_stage_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_out_reg))
        else $error("read stage lost a word while stalled");

    a_close_length : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s1_out_next.frame_closed |=> pending_len_reg == $past(write_index_reg))
        else $error("closed frame length differs from write index");

endmodule

// ===== tb/framer_checker.sv =====
// checker for the framer: follows both channels, predicts every result word and compares it
`timescale 1ns / 1ps
module framer_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  sitf_pkg::sitf_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  sitf_pkg::sitf_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_wdata,
    output int                  mismatch_count,
    output int                  words_in_flight,
    output int                  filled_depth
);

    logic        ym_mode;
    logic [11:0] soh_thr;
    logic [11:0] stx_thr;
    logic [5:0]  retry_lim;

    logic [7:0]  rx_mem [sitf_pkg::BUF_DEPTH];
    logic [7:0]  lead_byte;
    logic [11:0] wr_idx;
    logic [11:0] pend_len;
    logic [5:0]  retries;
    logic        tmr_on;
    int          high_water;
    int          fail_tally = 0;

    sitf_pkg::sitf_out_t awaited_results [$];

    function automatic void seal_frame();
        pend_len = wr_idx;
        wr_idx   = '0;
    endfunction

    function automatic sitf_pkg::sitf_out_t advance_framer(sitf_pkg::sitf_in_t w);
        sitf_pkg::sitf_out_t r;
        logic [11:0]         thr;
        r = '0;
        case (w.kind)
            sitf_pkg::KIND_BYTE: begin
                if (wr_idx >= sitf_pkg::BUF_DEPTH || pend_len != 0) begin
                    r.byte_dropped = 1'b1;
                end else begin
                    rx_mem[wr_idx[sitf_pkg::ADDR_W-1:0]] = w.rx_byte;
                    if (wr_idx == 0) begin
                        lead_byte = w.rx_byte;
                    end
                    wr_idx  = wr_idx + 1'b1;
                    retries = '0;
                    tmr_on  = 1'b1;
                    r.timer_restart = 1'b1;
                    if (int'(wr_idx) > high_water) begin
                        high_water = int'(wr_idx);
                    end
                end
            end
            sitf_pkg::KIND_EXPIRY: begin
                if (tmr_on) begin
                    if (!ym_mode || (lead_byte != sitf_pkg::CH_SOH
                                     && lead_byte != sitf_pkg::CH_STX)) begin
                        seal_frame();
                        r.frame_closed = 1'b1;
                        tmr_on = 1'b0;
                    end else begin
                        thr = (lead_byte == sitf_pkg::CH_SOH) ? soh_thr : stx_thr;
                        if (wr_idx >= thr) begin
                            seal_frame();
                            r.frame_closed = 1'b1;
                            tmr_on = 1'b0;
                        end else begin
                            r.timer_restart = 1'b1;
                            if (retries < sitf_pkg::RETRY_MAX) begin
                                retries = retries + 1'b1;
                            end
                            // timer keeps running after a retry close
                            if (retries > retry_lim) begin
                                seal_frame();
                                r.frame_closed = 1'b1;
                            end
                        end
                    end
                end
            end
            sitf_pkg::KIND_RELEASE: begin
                pend_len = '0;
            end
            sitf_pkg::KIND_READ: begin
                if (w.read_index < sitf_pkg::BUF_DEPTH) begin
                    r.read_data = rx_mem[w.read_index];
                end
            end
            default: begin
            end
        endcase
        r.frame_length = pend_len;
        r.timer_enable = tmr_on;
        return r;
    endfunction

    function automatic int field_bad(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        sitf_pkg::sitf_out_t want;
        if (!aresetn) begin
            ym_mode    = 1'b0;
            soh_thr    = sitf_pkg::SHORT_THR_RESET;
            stx_thr    = sitf_pkg::LONG_THR_RESET;
            retry_lim  = sitf_pkg::RETRY_LIMIT_RESET;
            lead_byte  = '0;
            wr_idx     = '0;
            pend_len   = '0;
            retries    = '0;
            tmr_on     = 1'b0;
            high_water = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word %h arrived, expected none", $time, m_data);
                    fail_tally++;
                end else begin
                    want = awaited_results.pop_front();
                    fail_tally += field_bad("read_data", 12'(want.read_data),
                                            12'(m_data.read_data));
                    fail_tally += field_bad("frame_length", want.frame_length,
                                            m_data.frame_length);
                    fail_tally += field_bad("frame_closed", 12'(want.frame_closed),
                                            12'(m_data.frame_closed));
                    fail_tally += field_bad("timer_enable", 12'(want.timer_enable),
                                            12'(m_data.timer_enable));
                    fail_tally += field_bad("timer_restart", 12'(want.timer_restart),
                                            12'(m_data.timer_restart));
                    fail_tally += field_bad("byte_dropped", 12'(want.byte_dropped),
                                            12'(m_data.byte_dropped));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    sitf_pkg::CFG_YMODEM_MODE: ym_mode   = cfg_wdata[0];
                    sitf_pkg::CFG_SHORT_THR:   soh_thr   = cfg_wdata;
                    sitf_pkg::CFG_LONG_THR:    stx_thr   = cfg_wdata;
                    sitf_pkg::CFG_RETRY_LIMIT: retry_lim = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(advance_framer(s_data));
            end
        end
        mismatch_count  <= fail_tally;
        words_in_flight <= awaited_results.size();
        filled_depth    <= high_water;
    end

endmodule

// ===== tb/testbench.sv =====
// top of the framer testbench: clock, reset, stimulus, stalls and the verdict
`timescale 1ns / 1ps
module testbench;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    sitf_pkg::sitf_in_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    sitf_pkg::sitf_out_t m_data;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = sitf_pkg::CFG_YMODEM_MODE;
    logic [11:0]         cfg_wdata = '0;

    int mismatch_count;
    int words_in_flight;
    int filled_depth;
    int words_sent  = 0;
    int ready_hold  = 0;
    bit steady      = 1'b0;
    int pkt_len_max = 4;
    int expiry_max  = 3;

    serial_idle_timeout_framer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    framer_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight),
        .filled_depth    (filled_depth)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 60) begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 2);
        end
        if (r < 96) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 25);
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] rx,
                             input logic [10:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= {op, rx, idx};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // only entries written since reset may be read back
    task automatic send_read();
        if (filled_depth > 0) begin
            send_word(sitf_pkg::KIND_READ, 8'($urandom),
                      11'($urandom_range(0, filled_depth - 1)));
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_in_flight != 0);
    endtask

    task automatic program_regs(input logic ym, input logic [11:0] sthr,
                                input logic [11:0] lthr, input logic [5:0] lim);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= sitf_pkg::CFG_YMODEM_MODE;
        cfg_wdata <= {11'd0, ym};
        @(posedge aclk);
        cfg_index <= sitf_pkg::CFG_SHORT_THR;
        cfg_wdata <= sthr;
        @(posedge aclk);
        cfg_index <= sitf_pkg::CFG_LONG_THR;
        cfg_wdata <= lthr;
        @(posedge aclk);
        cfg_index <= sitf_pkg::CFG_RETRY_LIMIT;
        cfg_wdata <= {6'd0, lim};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_packet();
        int         n;
        int         pick;
        logic [7:0] lead;
        if ($urandom_range(0, 3) != 0) begin
            send_word(sitf_pkg::KIND_RELEASE, 8'($urandom), 11'($urandom));
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            lead = sitf_pkg::CH_SOH;
        end else if (pick < 8) begin
            lead = sitf_pkg::CH_STX;
        end else begin
            lead = 8'($urandom);
        end
        send_word(sitf_pkg::KIND_BYTE, lead, 11'($urandom));
        n = $urandom_range(0, pkt_len_max);
        repeat (n) begin
            send_word(sitf_pkg::KIND_BYTE, 8'($urandom), 11'($urandom));
            if ($urandom_range(0, 7) == 0) begin
                send_word(sitf_pkg::KIND_EXPIRY, 8'($urandom), 11'($urandom));
            end
        end
        repeat ($urandom_range(1, expiry_max)) begin
            send_word(sitf_pkg::KIND_EXPIRY, 8'($urandom), 11'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_read();
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (op == sitf_pkg::KIND_READ) begin
            send_read();
        end else begin
            send_word(op, 8'($urandom), 11'($urandom));
        end
    endtask

    task automatic random_traffic(input int budget);
        int stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                send_packet();
            end else begin
                send_noise();
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain command input with reset settings
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'hFF, 11'h7FF);
        send_word(sitf_pkg::KIND_BYTE, 8'h00, 11'h7FF);
        send_word(sitf_pkg::KIND_BYTE, 8'hFF, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'h5A, 11'h2AA);
        send_word(sitf_pkg::KIND_READ, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_READ, 8'hFF, 11'd1);
        send_word(sitf_pkg::KIND_READ, 8'h00, 11'd2);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'h33, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_SOH, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        pkt_len_max = 6;
        expiry_max  = 2;
        random_traffic(150);

        // packet mode, retry limit zero, close at index zero wipes a pending frame
        program_regs(1'b1, 12'd3, 12'd5, 6'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_SOH, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'hC3, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_STX, 11'd0);
        repeat (4) send_word(sitf_pkg::KIND_BYTE, 8'($urandom), 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'h7E, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'h81, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        pkt_len_max = 7;
        expiry_max  = 3;
        random_traffic(150);

        // full buffer, thresholds at the buffer depth, retry count saturating past the limit
        program_regs(1'b1, 12'd2048, 12'd2048, 6'd62);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_STX, 11'd0);
        repeat (sitf_pkg::BUF_DEPTH + 1) begin
            send_word(sitf_pkg::KIND_BYTE, 8'($urandom), 11'($urandom));
        end
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_READ, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_READ, 8'hFF, 11'h7FF);
        repeat (30) send_read();
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_SOH, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, 8'h99, 11'd0);
        repeat (66) send_word(sitf_pkg::KIND_EXPIRY, 8'($urandom), 11'($urandom));
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);

        // retry limit at the saturation point never closes
        program_regs(1'b1, 12'd2048, 12'd2048, 6'd63);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_STX, 11'd0);
        repeat (3) send_word(sitf_pkg::KIND_BYTE, 8'($urandom), 11'd0);
        repeat (66) send_word(sitf_pkg::KIND_EXPIRY, 8'($urandom), 11'($urandom));
        send_word(sitf_pkg::KIND_BYTE, 8'h10, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        pkt_len_max = 4;
        expiry_max  = 70;
        random_traffic(150);

        // zero short threshold closes on the first expiry
        program_regs(1'b1, 12'd0, 12'd1, 6'd5);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_SOH, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_RELEASE, 8'h00, 11'd0);
        send_word(sitf_pkg::KIND_BYTE, sitf_pkg::CH_STX, 11'd0);
        send_word(sitf_pkg::KIND_EXPIRY, 8'h00, 11'd0);
        pkt_len_max = 3;
        expiry_max  = 8;
        random_traffic(150);

        // plain input again, no idling on either side
        program_regs(1'b0, 12'd1, 12'd2048, 6'd0);
        steady      = 1'b1;
        pkt_len_max = 5;
        expiry_max  = 2;
        random_traffic(150);
        steady = 1'b0;

        program_regs(1'b1, 12'd6, 12'd10, 6'd3);
        pkt_len_max = 12;
        expiry_max  = 6;
        random_traffic(250);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && words_in_flight == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sitf_pkg.sv
design/serial_idle_timeout_framer_unit.sv
tb/framer_checker.sv
tb/testbench.sv
